[rtl/mbps_pkg.sv]
// ----------------------------------------------------------------------------
// mbps_pkg
// Shared constants, types and helpers for the masked byte pattern scanner.
// ----------------------------------------------------------------------------
package mbps_pkg;

    localparam int MAX_PATTERN  = 16;
    localparam int OFFSET_BITS  = 32;
    localparam int PAT_BYTES    = 16;
    localparam int LEN_BITS     = $clog2(MAX_PATTERN + 1);
    localparam int WIN_IDX_BITS = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

    localparam int BYTE_BITS    = 8;
    localparam int MATCH_BITS   = 32;
    localparam int CFG_IDX_BITS = 8;
    localparam int CFG_DAT_BITS = 64;
    localparam int PLEN_BITS    = 5;
    localparam int CARE_BITS    = 16;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_BITS-1:0] REG_PATTERN_LOW    = CFG_IDX_BITS'(0);
    localparam logic [CFG_IDX_BITS-1:0] REG_PATTERN_HIGH   = CFG_IDX_BITS'(1);
    localparam logic [CFG_IDX_BITS-1:0] REG_CARE_MASK      = CFG_IDX_BITS'(2);
    localparam logic [CFG_IDX_BITS-1:0] REG_PATTERN_LENGTH = CFG_IDX_BITS'(3);

    localparam logic [CARE_BITS-1:0] CARE_RESET = '1;
    localparam logic [PLEN_BITS-1:0] PLEN_RESET = PLEN_BITS'(1);

    typedef struct packed {
        logic [63:0]          pattern_high;
        logic [63:0]          pattern_low;
        logic [CARE_BITS-1:0] care_mask;
        logic [PLEN_BITS-1:0] pattern_length;
    } t_cfg;

    typedef struct packed {
        logic                   hit;
        logic [MATCH_BITS-1:0]  offset;
    } t_scan_res;

    // zero acts as one, anything above the window depth is clamped
    function automatic logic [LEN_BITS-1:0] active_length(input logic [PLEN_BITS-1:0] plen);
        logic [31:0] wide;
        wide = 32'(plen);
        if (plen == '0) begin
            return LEN_BITS'(1);
        end else if (wide > 32'(MAX_PATTERN)) begin
            return LEN_BITS'(MAX_PATTERN);
        end else begin
            return LEN_BITS'(plen);
        end
    endfunction

endpackage

[rtl/mbps_in_if.sv]
// ----------------------------------------------------------------------------
// mbps_in_if
// Byte stream channel into the scanner.
// ----------------------------------------------------------------------------
interface mbps_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] mem_byte;
    logic       region_start;

    modport source (output valid, output mem_byte, output region_start, input ready);
    modport sink   (input valid, input mem_byte, input region_start, output ready);
endinterface

[rtl/mbps_out_if.sv]
// ----------------------------------------------------------------------------
// mbps_out_if
// Match result channel out of the scanner.
// ----------------------------------------------------------------------------
interface mbps_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] match_offset;

    modport source (output valid, output match_offset, input ready);
    modport sink   (input valid, input match_offset, output ready);
endinterface

[rtl/mbps_cfg_if.sv]
// ----------------------------------------------------------------------------
// mbps_cfg_if
// Register write channel of the scanner.
// ----------------------------------------------------------------------------
interface mbps_cfg_if;
    logic        valid;
    logic        ready;
    logic [7:0]  index;
    logic [63:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

[rtl/mbps_cfg_regs.sv]
// ----------------------------------------------------------------------------
// mbps_cfg_regs
// Pattern, care mask and length registers, written over the config channel.
// ----------------------------------------------------------------------------
module mbps_cfg_regs (
    input  logic           i_clk,
    input  logic           i_rst_n,
    mbps_cfg_if.sink       i_cfg,
    output mbps_pkg::t_cfg o_cfg
);
    import mbps_pkg::*;

    t_cfg r_cfg;

    assign i_cfg.ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pattern_low    <= '0;
            r_cfg.pattern_high   <= '0;
            r_cfg.care_mask      <= CARE_RESET;
            r_cfg.pattern_length <= PLEN_RESET;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                REG_PATTERN_LOW:    r_cfg.pattern_low    <= i_cfg.data;
                REG_PATTERN_HIGH:   r_cfg.pattern_high   <= i_cfg.data;
                REG_CARE_MASK:      r_cfg.care_mask      <= i_cfg.data[CARE_BITS-1:0];
                REG_PATTERN_LENGTH: r_cfg.pattern_length <= i_cfg.data[PLEN_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

endmodule

[rtl/mbps_scan_core.sv]
// ----------------------------------------------------------------------------
// mbps_scan_core
// Byte window, fresh count and offset counter with the masked window compare.
// ----------------------------------------------------------------------------
module mbps_scan_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_step,
    input  logic [7:0]          i_byte,
    input  logic                i_start,
    input  mbps_pkg::t_cfg      i_cfg,
    output mbps_pkg::t_scan_res o_res
);
    import mbps_pkg::*;

    logic [BYTE_BITS-1:0]   r_window [MAX_PATTERN];
    logic [BYTE_BITS-1:0]   n_window [MAX_PATTERN];
    logic [LEN_BITS-1:0]    r_fresh, n_fresh;
    logic [OFFSET_BITS-1:0] r_pos, n_pos;

    logic [LEN_BITS-1:0]    len;
    logic [LEN_BITS-1:0]    fresh_base;
    logic [LEN_BITS-1:0]    fresh_inc;
    logic [OFFSET_BITS-1:0] here;
    logic [OFFSET_BITS-1:0] start_off;
    logic [8*PAT_BYTES-1:0] pattern;
    logic                   miss;
    logic                   hit;
    logic [LEN_BITS-1:0]    win_sel;

    assign len     = active_length(i_cfg.pattern_length);
    assign pattern = {i_cfg.pattern_high, i_cfg.pattern_low};

    always_comb begin
        n_window[0] = i_byte;
        for (int j = 1; j < MAX_PATTERN; j++) begin
            n_window[j] = r_window[j-1];
        end
    end

    always_comb begin
        fresh_base = i_start ? '0 : r_fresh;
        fresh_inc  = (32'(fresh_base) < 32'(MAX_PATTERN)) ?
                     fresh_base + LEN_BITS'(1) : fresh_base;
        here       = i_start ? '0 : r_pos;
        n_pos      = here + OFFSET_BITS'(1);
    end

    // pattern byte k lines up with window entry len-1-k
    always_comb begin
        miss    = 1'b0;
        win_sel = '0;
        for (int k = 0; k < MAX_PATTERN; k++) begin
            win_sel = len - LEN_BITS'(1) - LEN_BITS'(k);
            if (k < PAT_BYTES) begin
                if ((LEN_BITS'(k) < len) && i_cfg.care_mask[k] &&
                    (n_window[win_sel[WIN_IDX_BITS-1:0]] != pattern[8*k +: 8])) begin
                    miss = 1'b1;
                end
            end
        end
        hit       = (fresh_inc >= len) && !miss;
        n_fresh   = hit ? '0 : fresh_inc;
        start_off = here - OFFSET_BITS'(len - LEN_BITS'(1));
    end

    assign o_res.hit    = hit;
    assign o_res.offset = MATCH_BITS'(start_off);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fresh <= '0;
            r_pos   <= '0;
        end else if (i_step) begin
            r_fresh <= n_fresh;
            r_pos   <= n_pos;
        end
    end

    // window contents are only compared once enough fresh bytes have arrived
    always_ff @(posedge i_clk) begin
        if (i_step) begin
            r_window <= n_window;
        end
    end

endmodule

[rtl/masked_byte_pattern_scanner.sv]
// ----------------------------------------------------------------------------
// masked_byte_pattern_scanner
// Streams region bytes against a wildcard pattern and reports match offsets.
// ----------------------------------------------------------------------------
// Usage:
//   i_cfg  : register writes (pattern low/high, care mask, length), always
//            ready; write only while the scanner is idle.
//   i_in   : one region byte per transfer, region_start flags the first byte
//            of a region and zeroes the offset and the fresh-byte count.
//   o_out  : one transfer per match, carrying the offset of the match's first
//            byte; issued for the transfer that delivers the last match byte.
// Matches are leftmost and never overlap; the search restarts after a match.
// Pipeline: each byte is registered in the input register, then its compare
// result is registered in the result register.
// Throughput: one byte per cycle while the receiver is not stalling.
// Reset clears the window count, the offset counter and both pipeline valids;
// registers return to pattern zero, care mask all ones, length one.
// When the receiver stalls the result register holds; one more byte is taken
// into the input register, then i_in.ready drops until the result is taken.
// ----------------------------------------------------------------------------
module masked_byte_pattern_scanner (
    input  logic        i_clk,
    input  logic        i_rst_n,
    mbps_cfg_if.sink    i_cfg,
    mbps_in_if.sink     i_in,
    mbps_out_if.source  o_out
);
    import mbps_pkg::*;

    t_cfg      cfg;
    t_scan_res res;

    logic                  r_s1_valid;
    logic [BYTE_BITS-1:0]  r_s1_byte;
    logic                  r_s1_start;
    logic                  r_out_valid;
    logic [MATCH_BITS-1:0] r_out_offset;

    logic advance;
    logic step;

    mbps_cfg_regs u_cfg_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (cfg)
    );

    mbps_scan_core u_scan_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_byte  (r_s1_byte),
        .i_start (r_s1_start),
        .i_cfg   (cfg),
        .o_res   (res)
    );

    // the compare stage moves whenever the result register is free
    assign advance = !r_out_valid || o_out.ready;
    assign step    = r_s1_valid && advance;

    assign i_in.ready         = !r_s1_valid || advance;
    assign o_out.valid        = r_out_valid;
    assign o_out.match_offset = r_out_offset;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_in.valid && i_in.ready) begin
            r_s1_valid <= 1'b1;
        end else if (advance) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_s1_byte  <= i_in.mem_byte;
            r_s1_start <= i_in.region_start;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= step && res.hit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step && res.hit) begin
            r_out_offset <= res.offset;
        end
    end

endmodule

[dv/masked_byte_pattern_scanner_tb.sv]
// ----------------------------------------------------------------------------
// masked_byte_pattern_scanner_tb
// Self-checking bench for the wildcard byte pattern scanner. A short table of
// directed bytes and register writes covers reset values, length clamping and
// all-wildcard masks. Random phases follow, each with its own pattern, mask,
// length and handshake pacing. Every accepted byte runs through a local scan
// model, and every match offset that comes out is checked in order.
// ----------------------------------------------------------------------------
module masked_byte_pattern_scanner_tb;
    import mbps_pkg::*;

    localparam int TARGET_ITEMS   = 1550;
    localparam int PHASE_ITEMS    = 170;
    localparam int DRAIN_CYCLES   = 4;
    localparam int WATCHDOG_LIMIT = 500;
    localparam int DIR_ROWS       = 30;

    typedef enum logic {ROW_WRITE, ROW_BYTE} t_row_kind;

    typedef struct {
        t_row_kind                kind;
        logic [CFG_IDX_BITS-1:0]  idx;
        logic [CFG_DAT_BITS-1:0]  data;
        logic [BYTE_BITS-1:0]     mem_byte;
        logic                     region_start;
        logic                     known;
        logic                     hit;
        logic [MATCH_BITS-1:0]    offset;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n;

    mbps_cfg_if cfg_if ();
    mbps_in_if  in_if ();
    mbps_out_if out_if ();

    masked_byte_pattern_scanner u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_if),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // scan model state and register copies
    logic [63:0]           pat_lo;
    logic [63:0]           pat_hi;
    logic [CARE_BITS-1:0]  care;
    logic [PLEN_BITS-1:0]  plen;
    logic [7:0]            win [MAX_PATTERN];
    int                    fresh;
    logic [31:0]           pos;

    logic [MATCH_BITS-1:0] pending_offsets [$];
    int                    mismatch_cnt = 0;
    int                    items_sent   = 0;
    int                    idle_cyc     = 0;

    // pacing
    int send_mode  = 1;
    int recv_mode  = 0;
    int burst_left = 0;

    // directed-row expectation carried alongside the byte being driven
    logic                  row_known;
    logic                  row_hit;
    logic [MATCH_BITS-1:0] row_off;

    logic                  mon_hit;
    logic [MATCH_BITS-1:0] mon_off;
    logic [MATCH_BITS-1:0] mon_exp;

    t_row dir_tab [DIR_ROWS];

    function automatic int act_len();
        if (plen == '0) begin
            return 1;
        end else if (int'(plen) > MAX_PATTERN) begin
            return MAX_PATTERN;
        end
        return int'(plen);
    endfunction

    function automatic logic scan_byte(input logic [7:0] b, input logic s,
                                       output logic [MATCH_BITS-1:0] off);
        int           len;
        logic [31:0]  here;
        logic [127:0] pat;
        logic         hit;
        len = act_len();
        pat = {pat_hi, pat_lo};
        off = '0;
        if (s) begin
            pos   = '0;
            fresh = 0;
        end
        here = pos;
        pos  = pos + 32'd1;
        for (int k = MAX_PATTERN - 1; k > 0; k--) begin
            win[k] = win[k-1];
        end
        win[0] = b;
        if (fresh < MAX_PATTERN) begin
            fresh++;
        end
        if (fresh < len) begin
            return 1'b0;
        end
        hit = 1'b1;
        for (int k = 0; k < len; k++) begin
            if (care[k] && win[len-1-k] != pat[8*k +: 8]) begin
                hit = 1'b0;
            end
        end
        if (!hit) begin
            return 1'b0;
        end
        fresh = 0;
        off   = here - 32'(len - 1);
        return 1'b1;
    endfunction

    function automatic t_row row_write(input logic [CFG_IDX_BITS-1:0] idx,
                                       input logic [CFG_DAT_BITS-1:0] data);
        t_row r;
        r = '{ROW_WRITE, idx, data, 8'h00, 1'b0, 1'b0, 1'b0, '0};
        return r;
    endfunction

    function automatic t_row row_byte(input logic [7:0] b, input logic s);
        t_row r;
        r = '{ROW_BYTE, '0, '0, b, s, 1'b0, 1'b0, '0};
        return r;
    endfunction

    function automatic t_row row_known_byte(input logic [7:0] b, input logic s,
                                            input logic hit,
                                            input logic [MATCH_BITS-1:0] off);
        t_row r;
        r = '{ROW_BYTE, '0, '0, b, s, 1'b1, hit, off};
        return r;
    endfunction

    function automatic logic [7:0] noise_byte(input logic narrow);
        if (narrow) begin
            return ($urandom_range(1) != 0) ? 8'h41 : 8'h42;
        end
        return 8'($urandom_range(255));
    endfunction

    // checker, register shadow, scan model, watchdog
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pat_lo = '0;
            pat_hi = '0;
            care   = CARE_RESET;
            plen   = PLEN_RESET;
            for (int k = 0; k < MAX_PATTERN; k++) begin
                win[k] = '0;
            end
            fresh    = 0;
            pos      = '0;
            idle_cyc = 0;
        end else begin
            if (out_if.valid && out_if.ready) begin
                if (pending_offsets.size() == 0) begin
                    $error("match_offset: expected no result, got %0d", out_if.match_offset);
                    mismatch_cnt++;
                end else begin
                    mon_exp = pending_offsets.pop_front();
                    if (out_if.match_offset !== mon_exp) begin
                        $error("match_offset: expected %0d, got %0d",
                               mon_exp, out_if.match_offset);
                        mismatch_cnt++;
                    end
                end
            end
            if (cfg_if.valid && cfg_if.ready) begin
                case (cfg_if.index)
                    REG_PATTERN_LOW: begin
                        pat_lo = cfg_if.data;
                    end
                    REG_PATTERN_HIGH: begin
                        pat_hi = cfg_if.data;
                    end
                    REG_CARE_MASK: begin
                        care = cfg_if.data[CARE_BITS-1:0];
                    end
                    REG_PATTERN_LENGTH: begin
                        plen = cfg_if.data[PLEN_BITS-1:0];
                    end
                    default: begin
                    end
                endcase
            end
            if (in_if.valid && in_if.ready) begin
                mon_hit = scan_byte(in_if.mem_byte, in_if.region_start, mon_off);
                if (row_known) begin
                    mon_hit = row_hit;
                    mon_off = row_off;
                end
                if (mon_hit) begin
                    pending_offsets.push_back(mon_off);
                end
            end
            if ((out_if.valid && out_if.ready) || (cfg_if.valid && cfg_if.ready)
                    || (in_if.valid && in_if.ready)) begin
                idle_cyc = 0;
            end else begin
                idle_cyc++;
            end
            if (idle_cyc >= WATCHDOG_LIMIT) begin
                $display("** masked_byte_pattern_scanner: FAILED **");
                $finish;
            end
        end
    end

    // receiver back-pressure
    initial begin
        int stall_left;
        int tick;
        stall_left   = 0;
        tick         = 0;
        out_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            tick++;
            case (recv_mode)
                0: begin
                    out_if.ready = 1'b1;
                end
                1: begin
                    out_if.ready = ($urandom_range(3) != 0);
                end
                2: begin
                    out_if.ready = ((tick % 7) < 4);
                end
                default: begin
                    if (stall_left > 0) begin
                        stall_left--;
                        out_if.ready = 1'b0;
                    end else if ($urandom_range(15) == 0) begin
                        stall_left   = $urandom_range(30, 5);
                        out_if.ready = 1'b0;
                    end else begin
                        out_if.ready = 1'b1;
                    end
                end
            endcase
        end
    end

    // all driver tasks start and end just after a falling edge
    task automatic send_byte(input logic [7:0] b, input logic s, input logic known,
                             input logic hit, input logic [MATCH_BITS-1:0] off);
        int gap;
        if (burst_left <= 0) begin
            if (send_mode != 0) begin
                gap = (send_mode == 1) ? $urandom_range(6, 1) : $urandom_range(2);
                if (gap > 0) begin
                    in_if.valid = 1'b0;
                    repeat (gap) @(negedge i_clk);
                end
            end
            burst_left = (send_mode == 0) ? 1000 :
                         (send_mode == 1) ? $urandom_range(12, 1) : $urandom_range(3, 1);
        end
        in_if.valid        = 1'b1;
        in_if.mem_byte     = b;
        in_if.region_start = s;
        row_known          = known;
        row_hit            = hit;
        row_off            = off;
        do @(posedge i_clk); while (!in_if.ready);
        @(negedge i_clk);
        burst_left--;
        items_sent++;
    endtask

    // hold off until every expected match is out and the pipe has emptied
    task automatic wait_idle();
        in_if.valid = 1'b0;
        burst_left  = 0;
        while (pending_offsets.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                             input logic [CFG_DAT_BITS-1:0] data);
        cfg_if.valid = 1'b1;
        cfg_if.index = idx;
        cfg_if.data  = data;
        do @(posedge i_clk); while (!cfg_if.ready);
        @(negedge i_clk);
        cfg_if.valid = 1'b0;
    endtask

    task automatic set_config(input logic [63:0] lo, input logic [63:0] hi,
                              input logic [CARE_BITS-1:0] cm,
                              input logic [PLEN_BITS-1:0] pl);
        logic [63:0] junk;
        junk = {$urandom, $urandom};
        wait_idle();
        write_reg(REG_PATTERN_LOW, lo);
        write_reg(REG_PATTERN_HIGH, hi);
        write_reg(REG_CARE_MASK, {junk[63:CARE_BITS], cm});
        write_reg(REG_PATTERN_LENGTH, {junk[63:PLEN_BITS], pl});
        // unmapped index, must leave everything alone
        if ($urandom_range(1) != 0) begin
            write_reg(CFG_IDX_BITS'($urandom_range(255, int'(REG_PATTERN_LENGTH) + 1)),
                      {$urandom, $urandom});
        end
    endtask

    task automatic run_phase(input int ph, input int n);
        logic [127:0]         pat;
        logic [CARE_BITS-1:0] cm;
        logic [PLEN_BITS-1:0] pl;
        logic                 narrow;
        logic                 paused;
        logic [7:0]           b;
        logic                 s;
        int                   len;
        int                   first;
        int                   bad;
        pat    = {$urandom, $urandom, $urandom, $urandom};
        cm     = CARE_BITS'($urandom);
        narrow = (ph % 3 == 2);
        paused = 1'b0;
        if (narrow) begin
            for (int k = 0; k < PAT_BYTES; k++) begin
                pat[8*k +: 8] = noise_byte(1'b1);
            end
        end
        case (ph % 8)
            0: begin
                pat = '0;
                cm  = '1;
                pl  = PLEN_BITS'(1);
            end
            1: begin
                pat = '1;
                cm  = '1;
                pl  = PLEN_BITS'(MAX_PATTERN);
            end
            2: begin
                pl = '0;
            end
            3: begin
                pl = '1;
            end
            4: begin
                cm = '0;
                pl = PLEN_BITS'($urandom_range(MAX_PATTERN, 1));
            end
            default: begin
                pl = PLEN_BITS'($urandom_range(31));
            end
        endcase
        set_config(pat[63:0], pat[127:64], cm, pl);
        send_mode = ph % 3;
        recv_mode = (ph / 2) % 4;
        len       = act_len();
        first     = items_sent;
        while (items_sent - first < n) begin
            if (!paused && items_sent - first >= n / 2) begin
                wait_idle();
                paused = 1'b1;
            end
            if ($urandom_range(9) < 6) begin
                // one pattern occurrence, sometimes with one byte broken
                bad = ($urandom_range(4) == 0) ? $urandom_range(len - 1) : -1;
                for (int k = 0; k < len; k++) begin
                    b = care[k] ? pat[8*k +: 8] : noise_byte(narrow);
                    if (k == bad) begin
                        b = b ^ 8'($urandom_range(255, 1));
                    end
                    s = (k == 0 && $urandom_range(7) == 0) || ($urandom_range(59) == 0);
                    send_byte(b, s, 1'b0, 1'b0, '0);
                end
            end else begin
                repeat ($urandom_range(len, 1)) begin
                    send_byte(noise_byte(narrow), $urandom_range(39) == 0, 1'b0, 1'b0, '0);
                end
            end
        end
    endtask

    initial begin
        int ph;
        i_rst_n            = 1'b0;
        cfg_if.valid       = 1'b0;
        cfg_if.index       = '0;
        cfg_if.data        = '0;
        in_if.valid        = 1'b0;
        in_if.mem_byte     = '0;
        in_if.region_start = 1'b0;
        row_known          = 1'b0;
        row_hit            = 1'b0;
        row_off            = '0;

        dir_tab = '{
            // reset pattern: length one, byte zero, all bytes cared
            row_known_byte(8'h00, 1'b1, 1'b1, 32'd0),
            row_known_byte(8'hff, 1'b0, 1'b0, 32'd0),
            row_known_byte(8'h00, 1'b0, 1'b1, 32'd2),
            // length zero behaves as one
            row_write(REG_PATTERN_LENGTH, 64'd0),
            row_known_byte(8'h00, 1'b0, 1'b1, 32'd3),
            row_write(REG_PATTERN_LOW, '1),
            row_known_byte(8'hff, 1'b1, 1'b1, 32'd0),
            row_known_byte(8'h00, 1'b0, 1'b0, 32'd0),
            // length 31 clamps to the full window; stale window bytes ignored
            row_write(REG_PATTERN_HIGH, '1),
            row_write(REG_PATTERN_LENGTH, 64'd31),
            row_known_byte(8'hff, 1'b1, 1'b0, 32'd0),
            row_known_byte(8'hff, 1'b0, 1'b0, 32'd0),
            row_known_byte(8'hff, 1'b0, 1'b0, 32'd0),
            row_known_byte(8'hff, 1'b0, 1'b0, 32'd0),
            row_known_byte(8'hff, 1'b0, 1'b0, 32'd0),
            row_known_byte(8'hff, 1'b0, 1'b0, 32'd0),
            row_known_byte(8'hff, 1'b0, 1'b0, 32'd0),
            row_known_byte(8'hff, 1'b0, 1'b0, 32'd0),
            row_known_byte(8'hff, 1'b0, 1'b0, 32'd0),
            row_known_byte(8'hff, 1'b0, 1'b0, 32'd0),
            row_known_byte(8'hff, 1'b0, 1'b0, 32'd0),
            row_known_byte(8'hff, 1'b0, 1'b0, 32'd0),
            row_known_byte(8'hff, 1'b0, 1'b0, 32'd0),
            row_known_byte(8'hff, 1'b0, 1'b0, 32'd0),
            row_known_byte(8'hff, 1'b0, 1'b0, 32'd0),
            row_known_byte(8'hff, 1'b0, 1'b1, 32'd0),
            // every byte a wildcard
            row_write(REG_CARE_MASK, 64'd0),
            row_write(REG_PATTERN_LENGTH, 64'd2),
            row_byte(8'h5a, 1'b1),
            row_byte(8'ha5, 1'b0)
        };

        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;

        for (int r = 0; r < DIR_ROWS; r++) begin
            if (dir_tab[r].kind == ROW_WRITE) begin
                wait_idle();
                write_reg(dir_tab[r].idx, dir_tab[r].data);
            end else begin
                send_byte(dir_tab[r].mem_byte, dir_tab[r].region_start,
                          dir_tab[r].known, dir_tab[r].hit, dir_tab[r].offset);
            end
        end

        ph = 0;
        while (items_sent < TARGET_ITEMS) begin
            run_phase(ph, PHASE_ITEMS);
            ph++;
        end

        wait_idle();
        repeat (8) @(negedge i_clk);
        if (pending_offsets.size() != 0) begin
            $error("match_offset: %0d expected results never arrived",
                   pending_offsets.size());
            mismatch_cnt++;
        end
        if (mismatch_cnt == 0) begin
            $display("** masked_byte_pattern_scanner: PASSED **");
        end else begin
            $display("** masked_byte_pattern_scanner: FAILED **");
        end
        $finish;
    end

endmodule
